FILE: rtl/core/swpr_pkg.sv
// shared constants and controller/datapath interface types for the peak rate monitor
package swpr_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned WIN_W          = 31;
  localparam int unsigned ENTRY_W        = 2 * DATA_W;
  localparam logic [WIN_W-1:0] WIN_RESET = 31'd60;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;   // take the incoming request, push it when timed
    logic pop;      // drop the oldest ring entry
    logic settle;   // latch the surviving oldest entry
    logic finish;   // update the peak and load the result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic occ_gt1;   // more than one entry in the ring
    logic need_pop;  // oldest entry is older than the window and is not the only entry
    logic out_free;  // result register can take a new result this cycle
  } status_t;

endpackage

FILE: rtl/core/swpr_ram.sv
// generic single-write, single-read memory with registered read data
module swpr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/swpr_datapath.sv
// ring buffer, counters, peak tracking and result register of the peak rate monitor
module swpr_datapath #(
  parameter int unsigned RING_DEPTH = swpr_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swpr_pkg::cmd_t               cmd_i,
  output swpr_pkg::status_t            status_o,
  input  logic                         cfg_valid_i,
  input  logic [swpr_pkg::WIN_W-1:0]   cfg_data_i,
  input  logic                         has_time_i,
  input  logic [swpr_pkg::DATA_W-1:0]  timestamp_i,
  input  logic                         server_error_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [swpr_pkg::DATA_W-1:0]  window_count_o,
  output logic [swpr_pkg::DATA_W-1:0]  peak_count_o,
  output logic [swpr_pkg::DATA_W-1:0]  peak_start_o,
  output logic [swpr_pkg::DATA_W-1:0]  peak_end_o,
  output logic [swpr_pkg::DATA_W-1:0]  error_total_o,
  output logic                         overflow_o
);
  import swpr_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned OCC_W = $clog2(RING_DEPTH + 1);

  function automatic logic [PTR_W-1:0] nxt_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [DATA_W-1:0] line_cnt_q, line_cnt_d, err_cnt_q, err_cnt_d;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [DATA_W-1:0] best_count_q, best_count_d, best_start_q, best_start_d;
  logic [DATA_W-1:0] best_end_q, best_end_d;
  logic              out_valid_q, out_valid_d;

  // item and tail entry payload
  logic [DATA_W-1:0] ts_q, line_q, tail_time_q, tail_line_q;
  logic              timed_q, ovf_q;
  logic [DATA_W-1:0] res_count_q, res_peak_q, res_start_q, res_end_q, res_err_q;
  logic              res_ovf_q;

  logic              full;
  logic [PTR_W-1:0]  tail_acc, tail_nxt, rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [DATA_W-1:0] rd_time, rd_line, age;
  logic              occ_gt1, drop;
  logic [DATA_W:0]   diff, inc;
  logic [DATA_W-1:0] count_raw, count_eff;
  logic              better;

  assign full     = (occ_q == OCC_W'(RING_DEPTH));
  assign tail_nxt = nxt_ptr(tail_q);
  assign tail_acc = full ? tail_nxt : tail_q;
  assign occ_gt1  = (occ_q > OCC_W'(1));

  always_comb begin
    priority if (cmd_i.accept) begin
      rd_addr = tail_acc;
    end else if (cmd_i.pop) begin
      rd_addr = tail_nxt;
    end else begin
      rd_addr = tail_q;
    end
  end

  swpr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept & has_time_i),
    .waddr_i(head_q),
    .wdata_i({timestamp_i, line_cnt_q}),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign rd_time = rd_data[ENTRY_W-1:DATA_W];
  assign rd_line = rd_data[DATA_W-1:0];

  // signed age, dropped only when positive and beyond the window
  assign age  = ts_q - rd_time;
  assign drop = ~age[DATA_W-1] & (age[WIN_W-1:0] > win_q);

  assign status_o.occ_gt1  = occ_gt1;
  assign status_o.need_pop = occ_gt1 & drop;
  assign status_o.out_free = ~out_valid_q | ~out_stall_i;

  // window count, saturating
  assign diff      = {1'b0, line_q} - {1'b0, tail_line_q};
  assign inc       = {1'b0, diff[DATA_W-1:0]} + {{DATA_W{1'b0}}, 1'b1};
  assign count_raw = diff[DATA_W] ? {{(DATA_W-1){1'b0}}, 1'b1} :
                     inc[DATA_W]  ? '1 : inc[DATA_W-1:0];
  assign count_eff = timed_q ? count_raw : '0;
  assign better    = (count_eff > best_count_q);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    line_cnt_d   = line_cnt_q;
    err_cnt_d    = err_cnt_q;
    win_d        = cfg_valid_i ? cfg_data_i : win_q;
    best_count_d = best_count_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    out_valid_d  = out_valid_q & out_stall_i;

    if (cmd_i.accept) begin
      if (line_cnt_q != '1) begin
        line_cnt_d = line_cnt_q + 1'b1;
      end
      if (server_error_i && err_cnt_q != '1) begin
        err_cnt_d = err_cnt_q + 1'b1;
      end
      if (has_time_i) begin
        head_d = nxt_ptr(head_q);
        tail_d = tail_acc;
        occ_d  = full ? occ_q : occ_q + 1'b1;
      end
    end

    if (cmd_i.pop) begin
      tail_d = tail_nxt;
      occ_d  = occ_q - 1'b1;
    end

    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (better) begin
        best_count_d = count_eff;
        best_start_d = tail_time_q;
        best_end_d   = ts_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      occ_q        <= '0;
      line_cnt_q   <= '0;
      err_cnt_q    <= '0;
      win_q        <= WIN_RESET;
      best_count_q <= '0;
      best_start_q <= '0;
      best_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      occ_q        <= occ_d;
      line_cnt_q   <= line_cnt_d;
      err_cnt_q    <= err_cnt_d;
      win_q        <= win_d;
      best_count_q <= best_count_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ts_q    <= timestamp_i;
      line_q  <= line_cnt_q;
      timed_q <= has_time_i;
      ovf_q   <= has_time_i & full;
    end
    if (cmd_i.settle) begin
      tail_time_q <= occ_gt1 ? rd_time : ts_q;
      tail_line_q <= occ_gt1 ? rd_line : line_q;
    end
    if (cmd_i.finish) begin
      res_count_q <= count_eff;
      res_peak_q  <= best_count_d;
      res_start_q <= best_start_d;
      res_end_q   <= best_end_d;
      res_err_q   <= err_cnt_q;
      res_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_count_o = res_count_q;
  assign peak_count_o   = res_peak_q;
  assign peak_start_o   = res_start_q;
  assign peak_end_o     = res_end_q;
  assign error_total_o  = res_err_q;
  assign overflow_o     = res_ovf_q;

endmodule

FILE: rtl/core/swpr_ctrl.sv
// sequencing state machine of the peak rate monitor
module swpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              has_time_i,
  output logic              in_stall_o,
  input  swpr_pkg::status_t status_i,
  output swpr_pkg::cmd_t    cmd_o
);
  import swpr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_FIN   = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = has_time_i ? ST_CHECK : ST_FIN;
        end
      end
      ST_CHECK: begin
        if (status_i.need_pop) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.settle = 1'b1;
          state_d      = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: rtl/core/sliding_window_peak_rate_core.sv
// top level of the sliding window peak rate monitor
//
// usage
// - input channel: in_valid_i / in_stall_o with has_time_i, timestamp_i and
//   server_error_i; one request per log record
// - output channel: out_valid_o / out_stall_i, one result request per record,
//   in record order
// - config channel: cfg_valid_i / cfg_ready_o writes the 31-bit window length;
//   ready is always high, write only while the block is idle
// - sequence: an untimed record goes from accept straight to finish; a timed
//   record goes through accept, one pop per expired ring entry, settle and finish,
//   with pops paced by the one read port of the ring memory (one entry checked
//   per cycle)
// - pops are bounded by pushes: each ring entry is popped at most once
// - the next record is accepted while a finished result still waits in the
//   output register; a held result only blocks the following record's finish
// - when the receiver stalls, the result register and its valid hold steady
// - reset clears pointers, counters and the peak, and sets the window to 60 s;
//   the ring memory itself is not cleared and needs no clearing pass
module sliding_window_peak_rate_core #(
  parameter int unsigned RING_DEPTH = swpr_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swpr_pkg::WIN_W-1:0]  cfg_data_i,
  // record input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        has_time_i,
  input  logic [swpr_pkg::DATA_W-1:0] timestamp_i,
  input  logic                        server_error_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [swpr_pkg::DATA_W-1:0] window_count_o,
  output logic [swpr_pkg::DATA_W-1:0] peak_count_o,
  output logic [swpr_pkg::DATA_W-1:0] peak_start_o,
  output logic [swpr_pkg::DATA_W-1:0] peak_end_o,
  output logic [swpr_pkg::DATA_W-1:0] error_total_o,
  output logic                        overflow_o
);
  import swpr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // the window register takes any write at once
  assign cfg_ready_o = 1'b1;

  // sequencer: accept, pop expired entries, settle on the oldest, finish; untimed records skip pop and settle
  swpr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .has_time_i(has_time_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // ring, counters, peak and result register
  swpr_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .has_time_i    (has_time_i),
    .timestamp_i   (timestamp_i),
    .server_error_i(server_error_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .window_count_o(window_count_o),
    .peak_count_o  (peak_count_o),
    .peak_start_o  (peak_start_o),
    .peak_end_o    (peak_end_o),
    .error_total_o (error_total_o),
    .overflow_o    (overflow_o)
  );

  // a pop never empties the ring: the newest entry always stays
  a_pop_keeps_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> status.occ_gt1)
    else $error("pop issued with a single ring entry");

  // a finished result never overwrites one the receiver has not taken
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // after a record is taken the block is busy until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> in_stall_o)
    else $error("second record taken while one is in flight");

  // an overflow only comes with a timed record, whose window holds at least itself
  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (window_count_o != '0))
    else $error("overflow reported with empty window");

endmodule
